FILE: rtl/image_meta_frame_parser_defines.svh
// Assertion macros for the image metadata frame parser.
// Included by the RTL files that carry assertions; assumes clk and rst_n in scope.
`ifndef IMAGE_META_FRAME_PARSER_DEFINES_SVH
`define IMAGE_META_FRAME_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define IMFP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imfp assertion failed");
// Next-cycle implication, checked outside reset.
`define IMFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imfp assertion failed");
`else
`define IMFP_ASSERT_IMPL(lbl, ante, cons)
`define IMFP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/imfp_pkg.sv
// Shared types, codes and constants of the image metadata frame parser.
// No dependencies.
`default_nettype none
package imfp_pkg;

  localparam int MAX_RECORDS = 8;
  localparam int FRAME_MAX   = 256;
  localparam int HDR_LEN     = 26;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);

  localparam logic [1:0] KIND_FIELD  = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_VALUE  = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_HDR_SHORT  = 3'd1;
  localparam logic [2:0] ST_ZERO_CHUNK = 3'd2;
  localparam logic [2:0] ST_OVERRUN    = 3'd3;
  localparam logic [2:0] ST_TOO_LONG   = 3'd4;

  localparam logic [3:0] FID_BLOCK = 4'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [3:0]  field_id;
    logic [31:0] field_value;
    logic [7:0]  record_type;
    logic [7:0]  record_length;
    logic [7:0]  record_number;
    logic [7:0]  value_byte;
    logic [2:0]  status;
    logic [7:0]  record_count;
    logic        final_res;
  } out_item_t;

  // One queue entry: what a single accepted byte produced.
  typedef struct packed {
    logic       has_data;
    out_item_t  data;
    logic       has_status;
    logic [2:0] status;
    logic [7:0] record_count;
  } imfp_entry_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } imfp_qstat_t;

  typedef struct packed {
    logic [3:0] id;
    logic [1:0] lane;
    logic       last;
  } fld_pos_t;

  // Header layout: which field a header offset belongs to, its byte lane,
  // and whether it is that field's last byte.
  function automatic fld_pos_t field_at(input logic [4:0] off);
    fld_pos_t p;
    p = '0;
    case (off)
      5'd1:  p = '{id: 4'd0,  lane: 2'd0, last: 1'b1};
      5'd2:  p = '{id: 4'd1,  lane: 2'd0, last: 1'b0};
      5'd3:  p = '{id: 4'd1,  lane: 2'd1, last: 1'b1};
      5'd4:  p = '{id: 4'd2,  lane: 2'd0, last: 1'b1};
      5'd5:  p = '{id: 4'd3,  lane: 2'd0, last: 1'b0};
      5'd6:  p = '{id: 4'd3,  lane: 2'd1, last: 1'b0};
      5'd7:  p = '{id: 4'd3,  lane: 2'd2, last: 1'b1};
      5'd8:  p = '{id: 4'd4,  lane: 2'd0, last: 1'b1};
      5'd9:  p = '{id: 4'd5,  lane: 2'd0, last: 1'b1};
      5'd10: p = '{id: 4'd6,  lane: 2'd0, last: 1'b0};
      5'd11: p = '{id: 4'd6,  lane: 2'd1, last: 1'b0};
      5'd12: p = '{id: 4'd6,  lane: 2'd2, last: 1'b0};
      5'd13: p = '{id: 4'd6,  lane: 2'd3, last: 1'b1};
      5'd14: p = '{id: 4'd7,  lane: 2'd0, last: 1'b0};
      5'd15: p = '{id: 4'd7,  lane: 2'd1, last: 1'b1};
      5'd16: p = '{id: 4'd8,  lane: 2'd0, last: 1'b0};
      5'd17: p = '{id: 4'd8,  lane: 2'd1, last: 1'b1};
      5'd18: p = '{id: 4'd9,  lane: 2'd0, last: 1'b1};
      5'd19: p = '{id: 4'd10, lane: 2'd0, last: 1'b1};
      5'd20: p = '{id: 4'd11, lane: 2'd0, last: 1'b0};
      5'd21: p = '{id: 4'd11, lane: 2'd1, last: 1'b1};
      5'd22: p = '{id: 4'd12, lane: 2'd0, last: 1'b0};
      5'd23: p = '{id: 4'd12, lane: 2'd1, last: 1'b0};
      5'd24: p = '{id: 4'd12, lane: 2'd2, last: 1'b0};
      5'd25: p = '{id: 4'd12, lane: 2'd3, last: 1'b1};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/imfp_front.sv
// Front part: accepts frame bytes, tracks header and record state, and
// builds one queue entry per byte. Depends on imfp_pkg and the defines header.
`default_nettype none
`include "image_meta_frame_parser_defines.svh"
module imfp_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  accept,
  input  imfp_pkg::in_item_t   in_item,
  output logic                 wr_en,
  output imfp_pkg::imfp_entry_t wr_entry
);
  import imfp_pkg::*;

  typedef enum logic [1:0] {
    PH_TYPE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  localparam logic [8:0] OFF_SAT = 9'd511;

  logic [8:0]  off_r, off_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        chunk_zero_r, chunk_zero_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  seen_r, seen_nxt;
  logic        too_long_r, too_long_nxt;

  logic [7:0]  b;
  fld_pos_t    pos;
  logic [7:0]  left_dec;
  logic [7:0]  seen_inc;
  imfp_entry_t ent;

  always_comb begin
    b            = in_item.data_byte;
    pos          = field_at(off_r[4:0]);
    left_dec     = left_r - 8'd1;
    seen_inc     = seen_r + 8'd1;
    off_nxt      = (off_r != OFF_SAT) ? off_r + 9'd1 : off_r;
    acc_nxt      = acc_r;
    chunk_zero_nxt = chunk_zero_r;
    phase_nxt    = phase_r;
    type_nxt     = type_r;
    left_nxt     = left_r;
    seen_nxt     = seen_r;
    too_long_nxt = too_long_r;
    ent          = '0;

    if (off_r >= 9'(FRAME_MAX)) begin
      too_long_nxt = 1'b1;
    end else if (off_r == 9'd0) begin
      // Control byte carries nothing for this parser.
    end else if (off_r < 9'(HDR_LEN)) begin
      if (pos.lane == 2'd0) begin
        acc_nxt = {24'd0, b};
      end else begin
        acc_nxt = acc_r | ({24'd0, b} << {pos.lane, 3'b000});
      end
      if (off_r == 9'd8 && b == 8'd0) begin
        chunk_zero_nxt = 1'b1;
      end
      if (pos.last) begin
        ent.has_data         = 1'b1;
        ent.data.record_kind = KIND_FIELD;
        ent.data.field_id    = pos.id;
        ent.data.field_value = acc_nxt;
        if (pos.id == FID_BLOCK && acc_nxt == 32'd0) begin
          ent.data.field_value = 32'd256;
        end
      end
    end else begin
      case (phase_r)
        PH_TYPE: begin
          type_nxt  = b;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          left_nxt                = b;
          ent.has_data            = 1'b1;
          ent.data.record_kind    = KIND_START;
          ent.data.record_type    = type_r;
          ent.data.record_length  = b;
          ent.data.record_number  = seen_r;
          if (b == 8'd0) begin
            seen_nxt  = seen_inc;
            phase_nxt = (seen_inc >= 8'(MAX_RECORDS)) ? PH_DONE : PH_TYPE;
          end else begin
            phase_nxt = PH_VALUE;
          end
        end
        PH_VALUE: begin
          ent.has_data           = 1'b1;
          ent.data.record_kind   = KIND_VALUE;
          ent.data.record_type   = type_r;
          ent.data.record_number = seen_r;
          ent.data.value_byte    = b;
          left_nxt               = left_dec;
          if (left_dec == 8'd0) begin
            seen_nxt  = seen_inc;
            phase_nxt = (seen_inc >= 8'(MAX_RECORDS)) ? PH_DONE : PH_TYPE;
          end
        end
        default: begin
        end
      endcase
    end

    if (in_item.frame_end) begin
      ent.has_status   = 1'b1;
      ent.record_count = seen_nxt;
      if (off_r < 9'(HDR_LEN - 1)) begin
        ent.status = ST_HDR_SHORT;
      end else if (chunk_zero_nxt) begin
        ent.status = ST_ZERO_CHUNK;
      end else if (phase_nxt == PH_VALUE) begin
        ent.status = ST_OVERRUN;
      end else if (too_long_nxt) begin
        ent.status = ST_TOO_LONG;
      end else begin
        ent.status = ST_OK;
      end
      off_nxt        = '0;
      acc_nxt        = '0;
      chunk_zero_nxt = 1'b0;
      phase_nxt      = PH_TYPE;
      type_nxt       = '0;
      left_nxt       = '0;
      seen_nxt       = '0;
      too_long_nxt   = 1'b0;
    end
  end

  assign wr_en    = accept && (ent.has_data || ent.has_status);
  assign wr_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r        <= '0;
      acc_r        <= '0;
      chunk_zero_r <= 1'b0;
      phase_r      <= PH_TYPE;
      type_r       <= '0;
      left_r       <= '0;
      seen_r       <= '0;
      too_long_r   <= 1'b0;
    end else if (accept) begin
      off_r        <= off_nxt;
      acc_r        <= acc_nxt;
      chunk_zero_r <= chunk_zero_nxt;
      phase_r      <= phase_nxt;
      type_r       <= type_nxt;
      left_r       <= left_nxt;
      seen_r       <= seen_nxt;
      too_long_r   <= too_long_nxt;
    end
  end

  // Once the record limit is hit, the count must stand at or above it.
  `IMFP_ASSERT_IMPL(a_done_has_limit, phase_r == PH_DONE, seen_r >= 8'(MAX_RECORDS))
  // A frame end always restarts the byte offset.
  `IMFP_ASSERT_NEXT(a_end_clears_off, accept && in_item.frame_end, off_r == 9'd0)

endmodule
`default_nettype wire

FILE: rtl/imfp_queue.sv
// Short entry queue that decouples the front and back parts.
// Depends on imfp_pkg and the defines header.
`default_nettype none
`include "image_meta_frame_parser_defines.svh"
module imfp_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   wr_en,
  input  imfp_pkg::imfp_entry_t wr_entry,
  input  wire                   rd_en,
  output imfp_pkg::imfp_entry_t rd_entry,
  output imfp_pkg::imfp_qstat_t qstat
);
  import imfp_pkg::*;

  imfp_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]    count_r, count_nxt;
  logic               do_wr, do_rd;

  assign qstat.full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign qstat.empty = (count_r == '0);
  assign do_wr       = wr_en && !qstat.full;
  assign do_rd       = rd_en && !qstat.empty;
  assign rd_entry    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // Occupancy and pointers must agree.
  `IMFP_ASSERT_IMPL(a_count_ptrs, !qstat.full, count_r[QPTR_W-1:0] == wr_ptr_r - rd_ptr_r)
  // The front part never writes into a full queue.
  `IMFP_ASSERT_IMPL(a_no_overflow, qstat.full, !wr_en)

endmodule
`default_nettype wire

FILE: rtl/imfp_back.sv
// Back part: turns the queue head into one or two results, the data result
// first and the frame status after it. Depends on imfp_pkg and the defines header.
`default_nettype none
`include "image_meta_frame_parser_defines.svh"
module imfp_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  imfp_pkg::imfp_entry_t head,
  input  imfp_pkg::imfp_qstat_t qstat,
  input  wire                   out_take,
  output logic                  rd_en,
  output imfp_pkg::out_item_t   out_item
);
  import imfp_pkg::*;

  // Set once the data half of a two-result entry has been taken.
  logic      data_sent_r;
  logic      show_data;
  out_item_t st_item;

  assign show_data = head.has_data && !data_sent_r;

  always_comb begin
    st_item              = '0;
    st_item.record_kind  = KIND_STATUS;
    st_item.status       = head.status;
    st_item.record_count = head.record_count;
    st_item.final_res    = 1'b1;
  end

  assign out_item = show_data ? head.data : st_item;
  assign rd_en    = out_take && !(show_data && head.has_status);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_sent_r <= 1'b0;
    end else if (out_take) begin
      data_sent_r <= show_data && head.has_status;
    end
  end

  // The split state only exists for a waiting entry that holds both results.
  `IMFP_ASSERT_IMPL(a_split_entry, data_sent_r,
                    !qstat.empty && head.has_data && head.has_status)

endmodule
`default_nettype wire

FILE: rtl/image_meta_frame_parser.sv
// Image metadata frame parser: one frame byte per cycle in unless the queue is full,
// one result per cycle out while the consumer pops. A result is queued when its byte
// is accepted and shown from the queue head; a frame's last byte may give two results,
// drained through the four-entry queue. Synchronous active-low reset
// empties the queue and clears all frame state. Depends on imfp_pkg and submodules.
`default_nettype none
module image_meta_frame_parser (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  output logic                 full,
  input  imfp_pkg::in_item_t   in_item,
  output logic                 empty,
  input  wire                  pop,
  output imfp_pkg::out_item_t  out_item
);
  import imfp_pkg::*;

  // The front part classifies every accepted byte against the header layout and
  // the record walk, and writes at most one entry per byte into the queue. Bytes
  // that give no result (the control byte, a record type byte, ignored bytes)
  // are consumed without touching the queue.
  logic        accept;
  logic        wr_en;
  logic        rd_en;
  imfp_entry_t wr_entry;
  imfp_entry_t head;
  imfp_qstat_t qstat;

  assign accept = push && !qstat.full;
  assign full   = qstat.full;
  assign empty  = qstat.empty;

  imfp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_item  (in_item),
    .wr_en    (wr_en),
    .wr_entry (wr_entry)
  );

  // The queue separates the two sides, so input keeps flowing while the
  // consumer holds off a waiting result, until the queue is full.
  imfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_entry (head),
    .qstat    (qstat)
  );

  // The back part splits an entry holding both a data result and a frame
  // status into two results, the data result first.
  imfp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .qstat    (qstat),
    .out_take (pop && !qstat.empty),
    .rd_en    (rd_en),
    .out_item (out_item)
  );

endmodule
`default_nettype wire

FILE: verif/image_meta_frame_parser_checker.sv
// Scoreboard for the image metadata frame parser: predicts the results of every accepted
// byte and compares them in order with what the parser hands out.
// Depends on imfp_pkg for the request and result types and the result codes.
module image_meta_frame_parser_checker
  import imfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  in_item_t    in_item,
  input  logic        empty,
  input  logic        pop,
  input  out_item_t   out_item,
  output int          mismatch_count,
  output int          results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    EXPECT_TYPE,
    EXPECT_LENGTH,
    IN_VALUE,
    RECORDS_DONE
  } rec_phase_t;

  // Header layout: first and last frame offset of each of the 13 fields.
  localparam logic [12:0][4:0] FIELD_FIRST = {5'd22, 5'd20, 5'd19, 5'd18, 5'd16, 5'd14,
                                              5'd10, 5'd9, 5'd8, 5'd5, 5'd4, 5'd2, 5'd1};
  localparam logic [12:0][4:0] FIELD_LAST  = {5'd25, 5'd21, 5'd19, 5'd18, 5'd17, 5'd15,
                                              5'd13, 5'd9, 5'd8, 5'd7, 5'd4, 5'd3, 5'd1};
  localparam int          FID_CHUNK    = 4;
  localparam logic [8:0]  OFFSET_SAT   = 9'd511;
  localparam int          PRINT_LIMIT  = 40;

  out_item_t  results_due[$];
  int         results_checked = 0;

  logic [8:0]  frame_offset  = '0;
  logic [31:0] field_acc     = '0;
  logic        chunk_zero    = 1'b0;
  rec_phase_t  rec_phase     = EXPECT_TYPE;
  logic [7:0]  rec_type      = '0;
  logic [7:0]  rec_left      = '0;
  logic [7:0]  rec_done_cnt  = '0;
  logic        over_length   = 1'b0;

  initial mismatch_count = 0;

  task automatic clear_frame_state();
    frame_offset = '0;
    field_acc    = '0;
    chunk_zero   = 1'b0;
    rec_phase    = EXPECT_TYPE;
    rec_type     = '0;
    rec_left     = '0;
    rec_done_cnt = '0;
    over_length  = 1'b0;
  endtask

  task automatic close_record();
    rec_done_cnt = rec_done_cnt + 8'd1;
    rec_phase = (rec_done_cnt >= MAX_RECORDS) ? RECORDS_DONE : EXPECT_TYPE;
  endtask

  // Works out the results that one frame byte causes and queues them.
  task automatic parse_frame_byte(input in_item_t req);
    logic [8:0]  at;
    int          k;
    logic [31:0] value;
    out_item_t   res;
    logic [2:0]  st;
    at = frame_offset;
    if (at >= FRAME_MAX) begin
      over_length = 1'b1;
    end else if (at == 0) begin
      // The control byte carries nothing that the parser reports.
    end else if (at < HDR_LEN) begin
      k = 0;
      while (k < 12 && at > FIELD_LAST[k]) k++;
      if (at == FIELD_FIRST[k]) field_acc = 32'(req.data_byte);
      else field_acc |= 32'(req.data_byte) << (8 * (at - FIELD_FIRST[k]));
      if (at == FIELD_FIRST[FID_CHUNK] && req.data_byte == 8'd0) chunk_zero = 1'b1;
      if (at == FIELD_LAST[k]) begin
        value = field_acc;
        if (k == FID_BLOCK && value == 0) value = 32'd256;
        res = '0;
        res.record_kind = KIND_FIELD;
        res.field_id = 4'(k);
        res.field_value = value;
        results_due.push_back(res);
      end
    end else begin
      case (rec_phase)
        EXPECT_TYPE: begin
          rec_type = req.data_byte;
          rec_phase = EXPECT_LENGTH;
        end
        EXPECT_LENGTH: begin
          rec_left = req.data_byte;
          res = '0;
          res.record_kind = KIND_START;
          res.record_type = rec_type;
          res.record_length = req.data_byte;
          res.record_number = rec_done_cnt;
          results_due.push_back(res);
          if (req.data_byte == 8'd0) close_record();
          else rec_phase = IN_VALUE;
        end
        IN_VALUE: begin
          res = '0;
          res.record_kind = KIND_VALUE;
          res.record_type = rec_type;
          res.record_number = rec_done_cnt;
          res.value_byte = req.data_byte;
          results_due.push_back(res);
          rec_left = rec_left - 8'd1;
          if (rec_left == 8'd0) close_record();
        end
        default: begin
        end
      endcase
    end

    if (frame_offset != OFFSET_SAT) frame_offset = frame_offset + 9'd1;

    if (req.frame_end) begin
      if (at + 1 < HDR_LEN) st = ST_HDR_SHORT;
      else if (chunk_zero) st = ST_ZERO_CHUNK;
      else if (rec_phase == IN_VALUE) st = ST_OVERRUN;
      else if (over_length) st = ST_TOO_LONG;
      else st = ST_OK;
      res = '0;
      res.record_kind = KIND_STATUS;
      res.status = st;
      res.record_count = rec_done_cnt;
      res.final_res = 1'b1;
      results_due.push_back(res);
      clear_frame_state();
    end
  endtask

  // Counts every mismatch; only the first PRINT_LIMIT are printed so that a broken
  // design does not flood the log.
  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_checked, name, got, want));
  endtask

  task automatic check_result(input out_item_t got, input out_item_t want);
    check_field("record_kind", 32'(got.record_kind), 32'(want.record_kind));
    check_field("field_id", 32'(got.field_id), 32'(want.field_id));
    check_field("field_value", got.field_value, want.field_value);
    check_field("record_type", 32'(got.record_type), 32'(want.record_type));
    check_field("record_length", 32'(got.record_length), 32'(want.record_length));
    check_field("record_number", 32'(got.record_number), 32'(want.record_number));
    check_field("value_byte", 32'(got.value_byte), 32'(want.value_byte));
    check_field("status", 32'(got.status), 32'(want.status));
    check_field("record_count", 32'(got.record_count), 32'(want.record_count));
    check_field("final_res", 32'(got.final_res), 32'(want.final_res));
  endtask

  // Prediction runs before the comparison so that a result that shows up in
  // the same cycle as its byte would still find its expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame_state();
      results_due.delete();
    end else begin
      if (push && !full) parse_frame_byte(in_item);
      if (pop && !empty) begin
        if (results_due.size() == 0)
          report_mismatch($sformatf("result of kind %0d with nothing expected",
                                    out_item.record_kind));
        else check_result(out_item, results_due.pop_front());
        results_checked++;
      end
    end
    results_pending <= results_due.size();
  end

endmodule

FILE: verif/image_meta_frame_parser_tb.sv
// Top of the image metadata frame parser testbench: clock, reset, frame stimulus,
// result draining and the verdict. Depends on imfp_pkg, the parser and its checker.
module image_meta_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import imfp_pkg::*;

  // Roughly how many frame bytes the whole run offers.
  localparam int TOTAL_BYTES    = 1550;
  // Cycles in a row without an accepted byte or a taken result before the run is declared hung.
  // The longest legal gap is the deliberate receiver hold-off below, well under this.
  localparam int WATCHDOG_LIMIT = 2000;
  // Length of the deliberate receiver hold-off.
  localparam int HOLD_CYCLES    = 80;
  // Extra settle time before the verdict, as a comfortable margin.
  localparam int SETTLE_CYCLES  = 10;

  typedef enum int {
    FR_CLEAN,
    FR_TRAIL_TYPE,
    FR_CUT,
    FR_JUNK_TAIL,
    FR_TOO_LONG
  } frame_style_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;

  int        mismatch_count;
  int        results_pending;

  // Idling knobs, in percent, changed from phase to phase by the stimulus.
  int        sender_idle_pct   = 0;
  int        receiver_stall_pct = 0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit        hold_request = 1'b0;
  int        bytes_sent = 0;
  int        stuck_cycles = 0;
  logic [7:0] frame_buf[$];

  always #6 clk = ~clk;

  image_meta_frame_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  image_meta_frame_parser_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_item         (in_item),
    .empty           (empty),
    .pop             (pop),
    .out_item        (out_item),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  // Bytes lean toward the extremes so that zero chunk and zero block size
  // values, and all-ones fields, come up often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Offers one byte and holds it until the parser takes it. The push level is
  // left high afterwards, so back-to-back bytes keep it high without a dip.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_item <= '{data_byte: b, frame_end: last};
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  task automatic send_frame_buf();
    for (int i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // Builds a frame with a full header and a run of records, then bends its
  // ending according to the style: a lone type byte after the last record,
  // a cut anywhere (short header or unfinished record), trailing junk that
  // either lands past the record limit or starts a broken record, or padding
  // beyond the maximum frame length.
  task automatic send_random_frame(input frame_style_t style);
    int nrec;
    int len;
    int cut;
    frame_buf.delete();
    for (int i = 0; i < HDR_LEN; i++) frame_buf.push_back(pick_byte());
    nrec = $urandom_range(MAX_RECORDS + 2);
    for (int r = 0; r < nrec; r++) begin
      len = ($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(5);
      frame_buf.push_back(pick_byte());
      frame_buf.push_back(8'(len));
      for (int j = 0; j < len; j++) frame_buf.push_back(pick_byte());
    end
    case (style)
      FR_TRAIL_TYPE: frame_buf.push_back(pick_byte());
      FR_CUT: begin
        cut = $urandom_range(frame_buf.size(), 1);
        while (frame_buf.size() > cut) void'(frame_buf.pop_back());
      end
      FR_JUNK_TAIL: begin
        len = $urandom_range(6, 1);
        for (int j = 0; j < len; j++) frame_buf.push_back(pick_byte());
      end
      FR_TOO_LONG: begin
        len = $urandom_range(FRAME_MAX + 14, FRAME_MAX + 1);
        while (frame_buf.size() < len) frame_buf.push_back(pick_byte());
      end
      default: begin
      end
    endcase
    send_frame_buf();
  endtask

  function automatic frame_style_t pick_style();
    int r;
    r = $urandom_range(19);
    if (r < 10) return FR_CLEAN;
    else if (r < 13) return FR_TRAIL_TYPE;
    else if (r < 17) return FR_CUT;
    else if (r < 19) return FR_JUNK_TAIL;
    else return FR_TOO_LONG;
  endfunction

  // Waits until every predicted result has been handed out. The first clock
  // edge lets the checker catch up with a byte accepted at this very edge.
  task automatic wait_for_drain();
    do @(posedge clk); while (results_pending != 0);
  endtask

  // Receiver side: pops at random according to the current stall rate, and
  // once on request holds off for a long stretch so the parser backs up.
  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        pop <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_request = 1'b0;
      end
      pop <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog: ends the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Stimulus and verdict.
  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_item = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames, all shorter than the header. A single byte gives only a
    // header-short status; two bytes add the one-byte session field at its
    // maximum; four bytes add a two-byte field and a one-byte field; the
    // twelve-byte frame has a zero chunk byte, which must lose to header short.
    frame_buf = {8'hFF};
    send_frame_buf();
    frame_buf = {8'h00, 8'hFF};
    send_frame_buf();
    frame_buf = {8'hA5, 8'hFF, 8'hFF, 8'h80};
    send_frame_buf();
    frame_buf = {8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
                 8'h00, 8'h09, 8'h0A, 8'h0B};
    send_frame_buf();

    // Random frames in four idling phases: none, sender mostly idle,
    // receiver mostly stalled, and light idling on both sides.
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct    = (ph == 1) ? 71 : (ph == 3) ? 10 : 0;
      receiver_stall_pct = (ph == 2) ? 71 : (ph == 3) ? 10 : 0;
      if (ph == 0) begin
        // One oversized frame early, so an over-length frame is always sent.
        send_random_frame(FR_TOO_LONG);
        // The receiver holds off while the sender keeps pushing at full rate,
        // which fills the parser's queue and stalls its input.
        hold_request = 1'b1;
        send_random_frame(FR_CLEAN);
        // The last byte must not be offered again while the results drain.
        push <= 1'b0;
        wait_for_drain();
      end
      while (bytes_sent < (ph + 1) * TOTAL_BYTES / 4) send_random_frame(pick_style());
      // The sender pauses here until every expected result has come out.
      push <= 1'b0;
      wait_for_drain();
    end

    push <= 1'b0;
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
